// ===== rtl/stt_pkg.sv =====
package stt_pkg;

  localparam int DIST_BITS  = 12;
  localparam int SLOPE_BITS = 14;
  localparam int ANGLE_BITS = 7;
  localparam int TRIG_BITS  = 16;
  localparam int PROD_BITS  = DIST_BITS + TRIG_BITS;

  // slope thresholds between the tangent tables, 8 fractional bits
  localparam logic [SLOPE_BITS-1:0] SLOPE_MID = 14'h067;
  localparam logic [SLOPE_BITS-1:0] SLOPE_ONE = 14'h100;
  localparam logic [SLOPE_BITS-1:0] SLOPE_TOP = 14'h258;

  localparam logic [ANGLE_BITS-1:0] ANGLE_ZERO  = 7'd0;
  localparam logic [ANGLE_BITS-1:0] ANGLE_RIGHT = 7'd90;

  localparam logic [15:0] TAN_LO [22] = '{
    16'h00, 16'h04, 16'h08, 16'h0d, 16'h11, 16'h16, 16'h1a, 16'h1f, 16'h23, 16'h28, 16'h2d,
    16'h31, 16'h36, 16'h3b, 16'h3f, 16'h44, 16'h49, 16'h4e, 16'h53, 16'h58, 16'h5d, 16'h62
  };
  localparam logic [15:0] TAN_MID [23] = '{
    16'h67, 16'h6c, 16'h71, 16'h77, 16'h7c, 16'h82, 16'h88, 16'h8d, 16'h93, 16'h99, 16'h9f,
    16'ha6, 16'hac, 16'hb3, 16'hb9, 16'hc0, 16'hc8, 16'hcf, 16'hd6, 16'hde, 16'he6, 16'hee,
    16'hf7
  };
  localparam logic [15:0] TAN_HI [22] = '{
    16'h0100, 16'h0109, 16'h0112, 16'h011c, 16'h0126, 16'h0131, 16'h013c, 16'h0147,
    16'h0153, 16'h0160, 16'h016d, 16'h017b, 16'h018a, 16'h0199, 16'h01aa, 16'h01bb,
    16'h01cd, 16'h01e1, 16'h01f6, 16'h020c, 16'h0224, 16'h023e
  };
  localparam logic [15:0] TAN_TOP [23] = '{
    16'h025b, 16'h0279, 16'h029a, 16'h02bf, 16'h02e7, 16'h0313, 16'h0345, 16'h037c,
    16'h03bb, 16'h0402, 16'h0454, 16'h04b4, 16'h0525, 16'h05ab, 16'h0650, 16'h071d,
    16'h0825, 16'h0983, 16'h0b6e, 16'h0e4d, 16'h1315, 16'h1ca3, 16'h394d
  };

  localparam logic [TRIG_BITS-1:0] SIN_TAB [90] = '{
    16'h0000, 16'h0477, 16'h08ef, 16'h0d65, 16'h11db, 16'h164f, 16'h1ac2, 16'h1f32,
    16'h23a0, 16'h280c, 16'h2c74, 16'h30d8, 16'h3539, 16'h3996, 16'h3dee, 16'h4242,
    16'h4690, 16'h4ad8, 16'h4f1b, 16'h5358, 16'h578e, 16'h5bbe, 16'h5fe6, 16'h6407,
    16'h681f, 16'h6c30, 16'h7039, 16'h7438, 16'h782f, 16'h7c1c, 16'h8000, 16'h83d9,
    16'h87a8, 16'h8b6d, 16'h8f27, 16'h92d5, 16'h9679, 16'h9a10, 16'h9d9c, 16'ha11b,
    16'ha48d, 16'ha7f3, 16'hab4c, 16'hae97, 16'hb1d5, 16'hb505, 16'hb826, 16'hbb3a,
    16'hbe3e, 16'hc134, 16'hc41b, 16'hc6f3, 16'hc9bb, 16'hcc73, 16'hcf1b, 16'hd1b4,
    16'hd43b, 16'hd6b3, 16'hd919, 16'hdb6f, 16'hddb3, 16'hdfe7, 16'he208, 16'he419,
    16'he617, 16'he803, 16'he9de, 16'heba6, 16'hed5b, 16'heeff, 16'hf08f, 16'hf20d,
    16'hf378, 16'hf4d0, 16'hf615, 16'hf746, 16'hf865, 16'hf970, 16'hfa67, 16'hfb4b,
    16'hfc1c, 16'hfcd9, 16'hfd82, 16'hfe17, 16'hfe99, 16'hff06, 16'hff60, 16'hffa6,
    16'hffd8, 16'hfff6
  };
  localparam logic [TRIG_BITS-1:0] COS_TAB [90] = '{
    16'hfff6, 16'hffd8, 16'hffa6, 16'hff60, 16'hff06, 16'hfe98, 16'hfe17, 16'hfd82,
    16'hfcd9, 16'hfc1c, 16'hfb4b, 16'hfa67, 16'hf970, 16'hf865, 16'hf746, 16'hf615,
    16'hf4d0, 16'hf378, 16'hf20d, 16'hf08f, 16'heeff, 16'hed5b, 16'heba6, 16'he9de,
    16'he803, 16'he617, 16'he418, 16'he208, 16'hdfe7, 16'hddb3, 16'hdb6f, 16'hd919,
    16'hd6b3, 16'hd43b, 16'hd1b3, 16'hcf1b, 16'hcc73, 16'hc9bb, 16'hc6f2, 16'hc41b,
    16'hc134, 16'hbe3e, 16'hbb39, 16'hb826, 16'hb504, 16'hb1d5, 16'hae97, 16'hab4c,
    16'ha7f3, 16'ha48d, 16'ha11b, 16'h9d9b, 16'h9a10, 16'h9678, 16'h92d5, 16'h8f27,
    16'h8b6d, 16'h87a8, 16'h83d9, 16'h7fff, 16'h7c1c, 16'h782f, 16'h7438, 16'h7038,
    16'h6c30, 16'h681f, 16'h6406, 16'h5fe6, 16'h5bbd, 16'h578e, 16'h5358, 16'h4f1b,
    16'h4ad8, 16'h468f, 16'h4241, 16'h3dee, 16'h3996, 16'h3539, 16'h30d8, 16'h2c73,
    16'h280b, 16'h23a0, 16'h1f32, 16'h1ac2, 16'h164f, 16'h11db, 16'h0d65, 16'h08ee,
    16'h0477, 16'h0000
  };

  // first-quadrant whole-degree angle from the slope; sat means slope beyond all tables
  function automatic logic [ANGLE_BITS-1:0] quad_angle(input logic [SLOPE_BITS-1:0] slope,
                                                        input logic sat);
    logic [4:0] c_lo, c_mid, c_hi, c_top;
    logic [ANGLE_BITS-1:0] a;
    c_lo  = '0;
    c_mid = '0;
    c_hi  = '0;
    c_top = '0;
    for (int i = 0; i < 22; i++) begin
      if (TAN_LO[i][SLOPE_BITS-1:0] <= slope) c_lo = c_lo + 5'd1;
      if (TAN_HI[i][SLOPE_BITS-1:0] <= slope) c_hi = c_hi + 5'd1;
    end
    for (int i = 0; i < 23; i++) begin
      if (TAN_MID[i][SLOPE_BITS-1:0] <= slope) c_mid = c_mid + 5'd1;
      if (TAN_TOP[i][SLOPE_BITS-1:0] <= slope) c_top = c_top + 5'd1;
    end
    if (sat) begin
      a = ANGLE_RIGHT;
    end else if (slope < SLOPE_ONE) begin
      if (slope >= SLOPE_MID) begin
        // slope just under one stays at 43 degrees
        a = (c_mid < 5'd23) ? 7'd21 + {2'b0, c_mid} : 7'd43;
      end else begin
        a = {2'b0, c_lo} - 7'd1;
      end
    end else if (slope >= SLOPE_TOP) begin
      a = (c_top < 5'd23) ? 7'd66 + {2'b0, c_top} : ANGLE_RIGHT;
    end else begin
      a = 7'd44 + {2'b0, c_hi};
    end
    return a;
  endfunction

  function automatic logic [TRIG_BITS-1:0] cos_val(input logic [ANGLE_BITS-1:0] a);
    logic [TRIG_BITS-1:0] v;
    v = '0;
    if (a != ANGLE_ZERO && a <= ANGLE_RIGHT) v = COS_TAB[a - 7'd1];
    return v;
  endfunction

  function automatic logic [TRIG_BITS-1:0] sin_val(input logic [ANGLE_BITS-1:0] a);
    logic [TRIG_BITS-1:0] v;
    v = '0;
    if (a < ANGLE_RIGHT) v = SIN_TAB[a];
    return v;
  endfunction

endpackage

// ===== rtl/stt_if.sv =====
interface stt_in_if #(parameter int COORD_BITS = 16);
  import stt_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] cur_x;
  logic [COORD_BITS-1:0] cur_y;
  logic [COORD_BITS-1:0] target_x;
  logic [COORD_BITS-1:0] target_y;
  logic [DIST_BITS-1:0]  step_dist;
  modport source(output valid, cur_x, cur_y, target_x, target_y, step_dist, input ready);
  modport sink(input valid, cur_x, cur_y, target_x, target_y, step_dist, output ready);
endinterface

interface stt_out_if #(parameter int COORD_BITS = 16);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] new_x;
  logic [COORD_BITS-1:0] new_y;
  modport source(output valid, new_x, new_y, input ready);
  modport sink(input valid, new_x, new_y, output ready);
endinterface

// ===== rtl/stt_div_step.sv =====
// two restoring quotient bits of the slope division
module stt_div_step #(
  parameter int COORD_BITS = 16,
  parameter int HI_BIT     = 13
) (
  input  logic [COORD_BITS+stt_pkg::SLOPE_BITS-1:0] rem_i,
  input  logic [COORD_BITS-1:0]                     ax_i,
  input  logic [stt_pkg::SLOPE_BITS-1:0]            q_i,
  output logic [COORD_BITS+stt_pkg::SLOPE_BITS-1:0] rem_o,
  output logic [stt_pkg::SLOPE_BITS-1:0]            q_o
);
  import stt_pkg::*;

  localparam int W = COORD_BITS + SLOPE_BITS;

  logic [W-1:0] d_hi, d_lo, rem_mid;
  logic [SLOPE_BITS-1:0] q_mid;

  assign d_hi = W'(ax_i) << HI_BIT;
  assign d_lo = W'(ax_i) << (HI_BIT - 1);

  always_comb begin
    rem_mid = rem_i;
    q_mid   = q_i;
    if (rem_i >= d_hi) begin
      rem_mid       = rem_i - d_hi;
      q_mid[HI_BIT] = 1'b1;
    end
    rem_o = rem_mid;
    q_o   = q_mid;
    if (rem_mid >= d_lo) begin
      rem_o           = rem_mid - d_lo;
      q_o[HI_BIT-1]   = 1'b1;
    end
  end

endmodule

// ===== rtl/step_toward_target.sv =====
// channel | modport          | payload
// in_i    | stt_in_if.sink   | cur_x, cur_y, target_x, target_y, step_dist
// out_o   | stt_out_if.source| new_x, new_y
//
// Eleven register stages: difference/halving, seven slope divider stages
// (two quotient bits each), angle lookup, trig multiply, add/clamp output.
// One item per cycle while out_o.ready is not held low.
// Reset clears all stage valid bits; payload registers are not reset.
// Each full stage holds while the one after it is full and stalled, so bubbles close up.
module step_toward_target #(
  parameter int COORD_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  stt_in_if.sink    in_i,
  stt_out_if.source out_o
);
  import stt_pkg::*;

  localparam int W      = COORD_BITS + SLOPE_BITS;
  localparam int SW     = (COORD_BITS > DIST_BITS ? COORD_BITS : DIST_BITS) + 2;
  localparam int NDIV   = SLOPE_BITS / 2;
  localparam int NSTAGE = NDIV + 3;

  typedef struct packed {
    logic [COORD_BITS-1:0] cur_x;
    logic [COORD_BITS-1:0] cur_y;
    logic [COORD_BITS-1:0] tgt_x;
    logic [COORD_BITS-1:0] tgt_y;
    logic [DIST_BITS-1:0]  step_len;
    logic                  byp;
    logic                  dxneg;
    logic                  dyneg;
    logic                  sat;
    logic [COORD_BITS-1:0] ax;
    logic [W-1:0]          rem;
    logic [SLOPE_BITS-1:0] slope;
    logic [ANGLE_BITS-1:0] angle;
    logic [DIST_BITS-1:0]  off_x;
    logic [DIST_BITS-1:0]  off_y;
  } pl_t;

  pl_t              pl_q  [NSTAGE];
  pl_t              pl_d  [NSTAGE];
  logic [NSTAGE-1:0] v_q;
  logic [NSTAGE:0]  rdy;

  logic [COORD_BITS-1:0] out_x_q, out_y_q, out_x_d, out_y_d;
  logic                  out_v_q;

  logic [W-1:0]          div_rem [NDIV];
  logic [SLOPE_BITS-1:0] div_q   [NDIV];

  // front stage signals
  logic signed [COORD_BITS:0] dx, dy, dxh, dyh;
  logic [COORD_BITS-1:0]      ax_full, ay_full, ax, ay;
  logic                       big;

  // back stage signals
  logic [PROD_BITS-1:0]  prod_c, prod_s;
  logic signed [SW-1:0]  sum_x, sum_y;

  always_comb begin
    rdy[NSTAGE] = !out_v_q || out_o.ready;
    for (int k = NSTAGE - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end
  assign in_i.ready = rdy[0];

  // difference, optional halving toward zero, magnitudes
  always_comb begin
    dx      = $signed({1'b0, in_i.target_x}) - $signed({1'b0, in_i.cur_x});
    dy      = $signed({1'b0, in_i.target_y}) - $signed({1'b0, in_i.cur_y});
    ax_full = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
    ay_full = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
    big     = (ax_full > COORD_BITS'(8'hff)) || (ay_full > COORD_BITS'(8'hff));
    dxh     = dx;
    dyh     = dy;
    if (big) begin
      dxh = (dx + $signed({{COORD_BITS{1'b0}}, dx[COORD_BITS]})) >>> 1;
      dyh = (dy + $signed({{COORD_BITS{1'b0}}, dy[COORD_BITS]})) >>> 1;
    end
    ax = dxh[COORD_BITS] ? COORD_BITS'(-dxh) : dxh[COORD_BITS-1:0];
    ay = dyh[COORD_BITS] ? COORD_BITS'(-dyh) : dyh[COORD_BITS-1:0];
  end

  for (genvar g = 0; g < NDIV; g++) begin : g_div
    stt_div_step #(
      .COORD_BITS(COORD_BITS),
      .HI_BIT    (SLOPE_BITS - 1 - 2 * g)
    ) u_div (
      .rem_i(pl_q[g].rem),
      .ax_i (pl_q[g].ax),
      .q_i  (pl_q[g].slope),
      .rem_o(div_rem[g]),
      .q_o  (div_q[g])
    );
  end

  assign prod_c = PROD_BITS'(pl_q[NDIV+1].step_len) * PROD_BITS'(cos_val(pl_q[NDIV+1].angle));
  assign prod_s = PROD_BITS'(pl_q[NDIV+1].step_len) * PROD_BITS'(sin_val(pl_q[NDIV+1].angle));

  always_comb begin
    pl_d[0]          = '0;
    pl_d[0].cur_x    = in_i.cur_x;
    pl_d[0].cur_y    = in_i.cur_y;
    pl_d[0].tgt_x    = in_i.target_x;
    pl_d[0].tgt_y    = in_i.target_y;
    pl_d[0].step_len = in_i.step_dist;
    pl_d[0].byp      = (in_i.step_dist == '0) ||
                       ((in_i.cur_x == in_i.target_x) && (in_i.cur_y == in_i.target_y));
    pl_d[0].dxneg    = dxh[COORD_BITS];
    pl_d[0].dyneg    = dyh[COORD_BITS];
    pl_d[0].ax       = ax;
    pl_d[0].rem      = W'(ay) << 8;
    // quotient would not fit the slope width: steeper than every table entry
    pl_d[0].sat      = (COORD_BITS+6)'(ay) >= ((COORD_BITS+6)'(ax) << 6);

    for (int k = 1; k <= NDIV; k++) begin
      pl_d[k]       = pl_q[k-1];
      pl_d[k].rem   = div_rem[k-1];
      pl_d[k].slope = div_q[k-1];
    end

    pl_d[NDIV+1]       = pl_q[NDIV];
    pl_d[NDIV+1].angle = quad_angle(pl_q[NDIV].slope, pl_q[NDIV].sat);

    pl_d[NDIV+2]       = pl_q[NDIV+1];
    pl_d[NDIV+2].off_x = (pl_q[NDIV+1].angle == ANGLE_ZERO) ? pl_q[NDIV+1].step_len :
                         prod_c[PROD_BITS-1:TRIG_BITS];
    pl_d[NDIV+2].off_y = (pl_q[NDIV+1].angle == ANGLE_RIGHT) ? pl_q[NDIV+1].step_len :
                         prod_s[PROD_BITS-1:TRIG_BITS];
  end

  // add offsets and clamp so neither axis passes the target; bypassed items keep the current position
  always_comb begin
    sum_x = $signed(SW'(pl_q[NSTAGE-1].cur_x));
    sum_y = $signed(SW'(pl_q[NSTAGE-1].cur_y));
    if (pl_q[NSTAGE-1].dxneg) sum_x = sum_x - $signed(SW'(pl_q[NSTAGE-1].off_x));
    else                      sum_x = sum_x + $signed(SW'(pl_q[NSTAGE-1].off_x));
    if (pl_q[NSTAGE-1].dyneg) sum_y = sum_y - $signed(SW'(pl_q[NSTAGE-1].off_y));
    else                      sum_y = sum_y + $signed(SW'(pl_q[NSTAGE-1].off_y));

    out_x_d = sum_x[COORD_BITS-1:0];
    out_y_d = sum_y[COORD_BITS-1:0];
    if (!pl_q[NSTAGE-1].dxneg) begin
      if (sum_x > $signed(SW'(pl_q[NSTAGE-1].tgt_x))) out_x_d = pl_q[NSTAGE-1].tgt_x;
    end else begin
      if (sum_x < $signed(SW'(pl_q[NSTAGE-1].tgt_x))) out_x_d = pl_q[NSTAGE-1].tgt_x;
    end
    if (!pl_q[NSTAGE-1].dyneg) begin
      if (sum_y > $signed(SW'(pl_q[NSTAGE-1].tgt_y))) out_y_d = pl_q[NSTAGE-1].tgt_y;
    end else begin
      if (sum_y < $signed(SW'(pl_q[NSTAGE-1].tgt_y))) out_y_d = pl_q[NSTAGE-1].tgt_y;
    end
    if (pl_q[NSTAGE-1].byp) begin
      out_x_d = pl_q[NSTAGE-1].cur_x;
      out_y_d = pl_q[NSTAGE-1].cur_y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (rdy[0]) v_q[0] <= in_i.valid;
      for (int k = 1; k < NSTAGE; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
      if (rdy[NSTAGE]) out_v_q <= v_q[NSTAGE-1];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NSTAGE; k++) begin
      if (rdy[k]) pl_q[k] <= pl_d[k];
    end
    if (rdy[NSTAGE]) begin
      out_x_q <= out_x_d;
      out_y_q <= out_y_d;
    end
  end

  assign out_o.valid = out_v_q;
  assign out_o.new_x = out_x_q;
  assign out_o.new_y = out_y_q;

endmodule
